/* sv/olie_pkg.sv */
// ----------------------------------------------------------------------------
// olie_pkg
// Request codes, status codes, FSM states and the cell control word of the ordered list
// insert engine.
// ----------------------------------------------------------------------------
package olie_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_HEAD  = 3'd1,
    OP_TAIL  = 3'd2,
    OP_POS   = 3'd3,
    OP_KEY   = 3'd4,
    OP_READ  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_NOPOS  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADIDX = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_t;

  typedef struct packed {
    logic        capture;
    logic        commit;
    logic        key_mode;
    logic [31:0] key;
    logic [31:0] ins_value;
  } cell_ctl_t;

endpackage

/* sv/olie_req_if.sv */
// ----------------------------------------------------------------------------
// olie_req_if
// Request channel: valid/ready handshake with the request word.
// ----------------------------------------------------------------------------
interface olie_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic signed [31:0] value;
  logic signed [31:0] new_value;
  logic [6:0]  position;

  modport source (output valid, output req_type, output value, output new_value,
                  output position, input ready);
  modport sink (input valid, input req_type, input value, input new_value,
                input position, output ready);
endinterface

/* sv/olie_rsp_if.sv */
// ----------------------------------------------------------------------------
// olie_rsp_if
// Response channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
interface olie_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  count;
  logic signed [31:0] read_value;

  modport source (output valid, output status, output count, output read_value,
                  input ready);
  modport sink (input valid, input status, input count, input read_value,
                output ready);
endinterface

/* sv/olie_cell.sv */
// ----------------------------------------------------------------------------
// olie_cell
// One list slot: holds an entry, matches it against the key, passes the
// insert boundary and read data to its right neighbor and shifts on insert.
// ----------------------------------------------------------------------------
module olie_cell #(
  parameter int CAPACITY = 64,
  parameter int INDEX    = 0,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  olie_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]       idx,
  input  logic [CW-1:0]       count,
  input  logic                ge_in,
  input  logic [31:0]         left_value,
  input  logic [31:0]         rd_in,
  output logic                ge_out,
  output logic [31:0]         value_out,
  output logic [31:0]         rd_out
);

  logic [31:0] value;
  logic        match;
  logic        pos_hit;
  logic        held;
  logic        mark;

  assign pos_hit   = (CW'(INDEX) == idx);
  assign held      = (CW'(INDEX) < count);
  assign mark      = ctl.key_mode ? (match && held) : pos_hit;
  assign ge_out    = ge_in | mark;
  assign rd_out    = rd_in | (pos_hit ? value : 32'd0);
  assign value_out = value;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= (value == ctl.key);
    end
    if (ctl.commit && ge_out) begin
      value <= ge_in ? left_value : ctl.ins_value;
    end
  end

endmodule

/* sv/ordered_list_insert_engine.sv */
// ----------------------------------------------------------------------------
// ordered_list_insert_engine
// Ordered list of signed words held in a row of cells; insert at head, tail,
// position or before a key, clear and read, one response word per request.
// Timing: in S_IDLE a request is accepted and the cells capture key matches;
// in S_EXEC no request is taken, and once the response register is free the
// cells resolve the insert boundary and shift; the response is registered.
// A pending response is held while the next request is accepted.
// Reset: entry count cleared, no response pending; entry values undefined.
// ----------------------------------------------------------------------------
module ordered_list_insert_engine #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  olie_req_if.sink   req,
  olie_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW + 1 > 7) ? CW + 1 : 7;

  olie_pkg::fsm_t    state, state_next;
  olie_pkg::op_t     req_op;
  logic [31:0]       req_value;
  logic [31:0]       req_new;
  logic [6:0]        req_pos;
  logic [CW-1:0]     entry_count, entry_count_next;
  logic              out_valid, out_valid_next;
  olie_pkg::status_t status_q, status_next;
  logic [6:0]        count_q;
  logic [31:0]       rdv_q, rdv_next;

  olie_pkg::cell_ctl_t ctl;
  logic [CW-1:0]     idx;
  logic              out_free;
  logic              ins_ok;
  logic              full;
  logic              pos_ok;
  logic              rd_ok;
  logic [PW-1:0]     pos_w;
  logic [PW-1:0]     cnt_w;
  logic [6:0]        pos_m1;

  logic              ge_chain [CAPACITY:0];
  logic [31:0]       rd_chain [CAPACITY:0];
  logic [31:0]       val_arr  [CAPACITY-1:0];

  assign ge_chain[0] = 1'b0;
  assign rd_chain[0] = 32'd0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left;
    if (i == 0) begin : g_first
      assign left = 32'd0;
    end else begin : g_rest
      assign left = val_arr[i-1];
    end
    olie_cell #(.CAPACITY(CAPACITY), .INDEX(i)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (idx),
      .count      (entry_count),
      .ge_in      (ge_chain[i]),
      .left_value (left),
      .rd_in      (rd_chain[i]),
      .ge_out     (ge_chain[i+1]),
      .value_out  (val_arr[i]),
      .rd_out     (rd_chain[i+1])
    );
  end

  assign req.ready      = (state == olie_pkg::S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = status_q;
  assign rsp.count      = count_q;
  assign rsp.read_value = rdv_q;

  assign out_free = !out_valid || rsp.ready;
  assign pos_m1   = req_pos - 7'd1;
  assign pos_w    = PW'(req_pos);
  assign cnt_w    = PW'(entry_count);
  assign full     = (entry_count == CW'(CAPACITY));
  assign pos_ok   = (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
  assign rd_ok    = (pos_w != '0) && (pos_w <= cnt_w);

  always_comb begin
    case (req_op)
      olie_pkg::OP_HEAD: idx = '0;
      olie_pkg::OP_TAIL: idx = entry_count;
      default:           idx = CW'(pos_m1);
    endcase
  end

  always_comb begin
    status_next      = olie_pkg::ST_DONE;
    rdv_next         = 32'd0;
    ins_ok           = 1'b0;
    entry_count_next = entry_count;
    case (req_op)
      olie_pkg::OP_CLEAR: begin
        entry_count_next = '0;
      end
      olie_pkg::OP_HEAD, olie_pkg::OP_TAIL: begin
        if (full) status_next = olie_pkg::ST_FULL;
        else ins_ok = 1'b1;
      end
      olie_pkg::OP_POS: begin
        if (full) status_next = olie_pkg::ST_FULL;
        else if (pos_ok) ins_ok = 1'b1;
        else status_next = olie_pkg::ST_NOPOS;
      end
      olie_pkg::OP_KEY: begin
        if (full) status_next = olie_pkg::ST_FULL;
        else if (ge_chain[CAPACITY]) ins_ok = 1'b1;
        else status_next = olie_pkg::ST_NOPOS;
      end
      olie_pkg::OP_READ: begin
        if (rd_ok) rdv_next = rd_chain[CAPACITY];
        else status_next = olie_pkg::ST_BADIDX;
      end
      default: begin
        status_next = olie_pkg::ST_NOPOS;
      end
    endcase
    if (ins_ok) entry_count_next = entry_count + CW'(1);
  end

  // A key insert with no match marks no cell, so the row is left as it is.
  always_comb begin
    ctl.capture   = req.valid && req.ready;
    ctl.commit    = (state == olie_pkg::S_EXEC) && out_free && !full &&
                    ((req_op inside {olie_pkg::OP_HEAD, olie_pkg::OP_TAIL,
                                     olie_pkg::OP_KEY}) ||
                     ((req_op == olie_pkg::OP_POS) && pos_ok));
    ctl.key_mode  = (req_op == olie_pkg::OP_KEY);
    ctl.key       = req.value;
    ctl.ins_value = (req_op == olie_pkg::OP_KEY) ? req_new : req_value;
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !rsp.ready;
    case (state)
      olie_pkg::S_IDLE: begin
        if (req.valid) state_next = olie_pkg::S_EXEC;
      end
      olie_pkg::S_EXEC: begin
        if (out_free) begin
          state_next     = olie_pkg::S_IDLE;
          out_valid_next = 1'b1;
        end
      end
      default: state_next = olie_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= olie_pkg::S_IDLE;
      out_valid   <= 1'b0;
      entry_count <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (state == olie_pkg::S_EXEC && out_free) begin
        entry_count <= entry_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_op    <= olie_pkg::op_t'(req.req_type);
      req_value <= req.value;
      req_new   <= req.new_value;
      req_pos   <= req.position;
    end
    if (state == olie_pkg::S_EXEC && out_free) begin
      status_q <= status_next;
      count_q  <= 7'(entry_count_next);
      rdv_q    <= rdv_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    state == olie_pkg::S_EXEC |-> !req.ready)
    else $error("request accepted while executing");

  a_commit_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && ins_ok |=> entry_count == $past(entry_count) + CW'(1))
    else $error("insert did not grow the list by one");

  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == olie_pkg::S_EXEC))
    else $error("response raised without execution");
`endif

endmodule
